// File: src/desvr_pkg.sv
// Shared constants for the drive enable sequencer with velocity ramp.
package desvr_pkg;

    // Drive command codes sent toward the drive
    localparam logic [2:0] CMD_FAULT_RESET = 3'd0;
    localparam logic [2:0] CMD_SHUTDOWN    = 3'd1;
    localparam logic [2:0] CMD_SWITCH_ON   = 3'd2;
    localparam logic [2:0] CMD_ENABLE      = 3'd3;
    localparam logic [2:0] CMD_DISABLE     = 3'd4;

    // Enable sequence steps
    localparam logic [2:0] STEP_FAULT_RESET = 3'd0;
    localparam logic [2:0] STEP_SHUTDOWN    = 3'd1;
    localparam logic [2:0] STEP_SWITCH_ON   = 3'd2;
    localparam logic [2:0] STEP_MODE_WAIT   = 3'd3;
    localparam logic [2:0] STEP_ENABLE      = 3'd4;

    // Statusword decoding
    localparam logic [15:0] MASK_STATE  = 16'h006F;
    localparam logic [15:0] ST_READY    = 16'h0021;
    localparam logic [15:0] ST_SWITCHED = 16'h0023;
    localparam logic [15:0] ST_ENABLED  = 16'h0027;
    localparam int BIT_OP_ENABLED     = 2;
    localparam int BIT_TARGET_REACHED = 10;

    // Sequencer timing and ramp
    localparam logic [6:0] RESET_CYCLES     = 7'd50;
    localparam logic [6:0] MODE_WAIT_CYCLES = 7'd100;
    localparam logic signed [17:0] RAMP_STEP = 18'sd5;

    // Operation mode codes
    localparam logic signed [7:0] MODE_CSV = 8'sd9;
    localparam logic signed [7:0] MODE_PVM = 8'sd3;

    // Configuration register indexes
    localparam logic [2:0] REG_OP_MODE      = 3'd0;
    localparam logic [2:0] REG_STICK_CENTER = 3'd1;
    localparam logic [2:0] REG_DEADZONE     = 3'd2;
    localparam logic [2:0] REG_STICK_MIN    = 3'd3;
    localparam logic [2:0] REG_STICK_MAX    = 3'd4;
    localparam logic [2:0] REG_FULL_LIMIT   = 3'd5;
    localparam logic [2:0] REG_REDUCED_LIM  = 3'd6;

    // Divider for the joystick map: product of 8 x 16 bits over a 9-bit divisor
    localparam int DVD_W     = 24;
    localparam int DSR_W     = 9;
    localparam int DIV_STEPS = DVD_W;

endpackage

// File: src/drive_enable_sequencer_velocity_ramp.sv
// Top level: drive enable sequencer with joystick velocity map and ramp.
//
// One input transfer per process-data cycle on the s_ channel carries the frame
// flags, statusword, shown mode and operator inputs; each transfer yields exactly
// one result transfer on the m_ channel with command, new-setpoint bit, velocity
// setpoint, operational flag and sequence step.
// From an input transfer the item passes through ST_PREP (the multiply), then the
// 24 steps of the restoring divider when the joystick map is evaluated, and
// ST_COMMIT, which sets m_tvalid. s_tready is high only while the sequencer is
// idle, so a new item is not taken until the last one is committed.
// A new item is taken while the previous result still waits on m_tready; the
// commit of that item then holds until the output register is free.
// Configuration writes on cfg_wr_en/cfg_addr/cfg_wdata take effect at once and
// are expected only between items. Indexes beyond the register list are ignored.
// Reset (aresetn low, synchronous) returns all but the latched item and divider
// registers to defaults, the sequencer to the fault-reset step and drops m_tvalid.
module drive_enable_sequencer_velocity_ramp
    import desvr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // frame_valid[0], stop_request[1], drive_status[17:2], mode_shown[25:18],
    // stick_position[33:26], speed_select[34], run_permit[35], motion_enable[36]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // drive_command[2:0], new_setpoint[3], velocity_setpoint[21:4],
    // is_operational[22], init_stage[25:23]
    output logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_COMMIT
    } fsm_t;

    fsm_t state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;

    // configuration
    logic signed [7:0] op_mode_reg, op_mode_next;
    logic [7:0]  center_reg, center_next;
    logic [6:0]  deadzone_reg, deadzone_next;
    logic [7:0]  stick_min_reg, stick_min_next;
    logic [7:0]  stick_max_reg, stick_max_next;
    logic [15:0] full_lim_reg, full_lim_next;
    logic [15:0] red_lim_reg, red_lim_next;

    // sequencer and velocity state
    logic        oper_reg, oper_next;
    logic [2:0]  step_reg, step_next;
    logic [6:0]  wait_reg, wait_next;
    logic signed [17:0] ramped_reg, ramped_next;
    logic signed [17:0] goal_reg, goal_next;
    logic        pending_reg, pending_next;
    logic signed [17:0] sent_vel_reg, sent_vel_next;
    logic [2:0]  sent_cmd_reg, sent_cmd_next;
    logic        sent_newsp_reg, sent_newsp_next;

    // latched item
    logic        in_valid_reg, in_valid_next;
    logic        in_stop_reg, in_stop_next;
    logic [15:0] in_status_reg, in_status_next;
    logic signed [7:0] in_shown_reg, in_shown_next;
    logic [7:0]  in_pos_reg, in_pos_next;
    logic        in_fast_reg, in_fast_next;
    logic        in_permit_reg, in_permit_next;
    logic        in_motion_reg, in_motion_next;

    // joystick map divider
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;

    logic signed [9:0] lo_s, hi_s, pos_s, den_s, diff_hi, diff_lo, den_neg_s;
    logic              above, below;
    logic [7:0]        num;
    logic [15:0]       lim;
    logic [DSR_W-1:0]  den_mag;
    logic [DSR_W:0]    trial;
    logic [16:0]       mag;
    logic signed [17:0] mapped;
    logic [15:0]       st_masked;
    logic              work_map;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, step_reg, oper_reg, sent_vel_reg, sent_newsp_reg, sent_cmd_reg};

    // joystick map front end: band edges, numerator and divisor
    always_comb begin
        lo_s    = signed'({2'b00, center_reg}) - signed'({3'b000, deadzone_reg});
        hi_s    = signed'({2'b00, center_reg}) + signed'({3'b000, deadzone_reg});
        pos_s   = signed'({2'b00, in_pos_reg});
        above   = pos_s > hi_s;
        below   = pos_s < lo_s;
        diff_hi = pos_s - hi_s;
        diff_lo = lo_s - pos_s;
        num     = above ? diff_hi[7:0] : diff_lo[7:0];
        den_s   = above ? (signed'({2'b00, stick_max_reg}) - hi_s)
                        : (lo_s - signed'({2'b00, stick_min_reg}));
        den_neg_s = -den_s;
        den_mag = den_s[9] ? den_neg_s[DSR_W-1:0] : den_s[DSR_W-1:0];
        lim     = in_fast_reg ? full_lim_reg : red_lim_reg;
        trial   = {rem_reg, dvd_reg[DVD_W-1]};
        // clamp quotient magnitude to the selected limit, then apply sign
        mag     = (dvd_reg > DVD_W'(lim)) ? {1'b0, lim} : {1'b0, dvd_reg[15:0]};
        if (zero_reg) begin
            mapped = '0;
        end else if (neg_reg) begin
            mapped = -signed'({1'b0, mag});
        end else begin
            mapped = signed'({1'b0, mag});
        end
        st_masked = in_status_reg & MASK_STATE;
        work_map  = in_valid_reg && !in_stop_reg && oper_reg
                    && in_status_reg[BIT_OP_ENABLED] && in_permit_reg && in_motion_reg;
    end

    always_comb begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg;
        op_mode_next    = op_mode_reg;
        center_next     = center_reg;
        deadzone_next   = deadzone_reg;
        stick_min_next  = stick_min_reg;
        stick_max_next  = stick_max_reg;
        full_lim_next   = full_lim_reg;
        red_lim_next    = red_lim_reg;
        oper_next       = oper_reg;
        step_next       = step_reg;
        wait_next       = wait_reg;
        ramped_next     = ramped_reg;
        goal_next       = goal_reg;
        pending_next    = pending_reg;
        sent_vel_next   = sent_vel_reg;
        sent_cmd_next   = sent_cmd_reg;
        sent_newsp_next = sent_newsp_reg;
        in_valid_next   = in_valid_reg;
        in_stop_next    = in_stop_reg;
        in_status_next  = in_status_reg;
        in_shown_next   = in_shown_reg;
        in_pos_next     = in_pos_reg;
        in_fast_next    = in_fast_reg;
        in_permit_next  = in_permit_reg;
        in_motion_next  = in_motion_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        zero_next       = zero_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_OP_MODE:      op_mode_next   = signed'(cfg_wdata[7:0]);
                REG_STICK_CENTER: center_next    = cfg_wdata[7:0];
                REG_DEADZONE:     deadzone_next  = cfg_wdata[6:0];
                REG_STICK_MIN:    stick_min_next = cfg_wdata[7:0];
                REG_STICK_MAX:    stick_max_next = cfg_wdata[7:0];
                REG_FULL_LIMIT:   full_lim_next  = cfg_wdata;
                REG_REDUCED_LIM:  red_lim_next   = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    in_valid_next  = s_tdata[0];
                    in_stop_next   = s_tdata[1];
                    in_status_next = s_tdata[17:2];
                    in_shown_next  = signed'(s_tdata[25:18]);
                    in_pos_next    = s_tdata[33:26];
                    in_fast_next   = s_tdata[34];
                    in_permit_next = s_tdata[35];
                    in_motion_next = s_tdata[36];
                    state_next     = ST_PREP;
                end
            end
            ST_PREP: begin
                dvd_next  = DVD_W'(num) * DVD_W'(lim);
                rem_next  = '0;
                dsr_next  = den_mag;
                cnt_next  = '0;
                neg_next  = den_s[9] ^ below;
                zero_next = !(above || below) || (den_mag == '0);
                if (work_map && (above || below) && (den_mag != '0)) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIV: begin
                // one restoring step per cycle; quotient shifts into dvd
                if (trial >= {1'b0, dsr_reg}) begin
                    rem_next = DSR_W'(trial - {1'b0, dsr_reg});
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[DSR_W-1:0];
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    if (in_stop_reg) begin
                        sent_vel_next   = '0;
                        sent_cmd_next   = CMD_DISABLE;
                        sent_newsp_next = 1'b0;
                    end else if (in_valid_reg && oper_reg) begin
                        if (!in_status_reg[BIT_OP_ENABLED]) begin
                            // enable bit lost: restart sequence, outputs repeat
                            oper_next = 1'b0;
                            step_next = STEP_FAULT_RESET;
                            wait_next = '0;
                        end else begin
                            if (!in_permit_reg) begin
                                goal_next = '0;
                            end else if (in_motion_reg) begin
                                goal_next = mapped;
                            end else begin
                                sent_vel_next = '0;
                            end
                            sent_newsp_next = 1'b0;
                            if (op_mode_reg == MODE_CSV) begin
                                if (goal_next > ramped_reg) begin
                                    ramped_next = ramped_reg + RAMP_STEP;
                                end else if (goal_next < ramped_reg) begin
                                    ramped_next = ramped_reg - RAMP_STEP;
                                end
                                sent_vel_next = ramped_next;
                            end else if (op_mode_reg == MODE_PVM) begin
                                if (goal_next != ramped_reg) begin
                                    sent_vel_next   = goal_next;
                                    ramped_next     = goal_next;
                                    sent_newsp_next = 1'b1;
                                    pending_next    = 1'b1;
                                end else if (pending_reg
                                             && in_status_reg[BIT_TARGET_REACHED]) begin
                                    pending_next = 1'b0;
                                end
                            end
                            sent_cmd_next = CMD_ENABLE;
                        end
                    end else if (in_valid_reg) begin
                        case (step_reg)
                            STEP_FAULT_RESET: begin
                                sent_cmd_next   = CMD_FAULT_RESET;
                                sent_newsp_next = 1'b0;
                                wait_next       = wait_reg + 7'd1;
                                if (wait_reg >= RESET_CYCLES) begin
                                    step_next = STEP_SHUTDOWN;
                                    wait_next = '0;
                                end
                            end
                            STEP_SHUTDOWN: begin
                                sent_cmd_next   = CMD_SHUTDOWN;
                                sent_newsp_next = 1'b0;
                                if (st_masked == ST_READY) begin
                                    step_next = STEP_SWITCH_ON;
                                end
                            end
                            STEP_SWITCH_ON: begin
                                sent_cmd_next   = CMD_SWITCH_ON;
                                sent_newsp_next = 1'b0;
                                if (st_masked == ST_SWITCHED) begin
                                    step_next = STEP_MODE_WAIT;
                                end
                            end
                            STEP_MODE_WAIT: begin
                                // command is left as it was
                                if (in_shown_reg == op_mode_reg) begin
                                    step_next = STEP_ENABLE;
                                    wait_next = '0;
                                end else begin
                                    wait_next = wait_reg + 7'd1;
                                    if (wait_reg >= MODE_WAIT_CYCLES) begin
                                        step_next = STEP_ENABLE;
                                        wait_next = '0;
                                    end
                                end
                            end
                            STEP_ENABLE: begin
                                sent_cmd_next   = CMD_ENABLE;
                                sent_newsp_next = 1'b0;
                                if (st_masked == ST_ENABLED) begin
                                    oper_next    = 1'b1;
                                    pending_next = 1'b0;
                                end
                            end
                            default: begin
                                step_next = STEP_FAULT_RESET;
                                wait_next = '0;
                            end
                        endcase
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            op_mode_reg    <= MODE_CSV;
            center_reg     <= 8'd128;
            deadzone_reg   <= 7'd10;
            stick_min_reg  <= 8'd4;
            stick_max_reg  <= 8'd252;
            full_lim_reg   <= 16'd2700;
            red_lim_reg    <= 16'd1500;
            oper_reg       <= 1'b0;
            step_reg       <= STEP_FAULT_RESET;
            wait_reg       <= '0;
            ramped_reg     <= '0;
            goal_reg       <= '0;
            pending_reg    <= 1'b0;
            sent_vel_reg   <= '0;
            sent_cmd_reg   <= CMD_FAULT_RESET;
            sent_newsp_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            op_mode_reg    <= op_mode_next;
            center_reg     <= center_next;
            deadzone_reg   <= deadzone_next;
            stick_min_reg  <= stick_min_next;
            stick_max_reg  <= stick_max_next;
            full_lim_reg   <= full_lim_next;
            red_lim_reg    <= red_lim_next;
            oper_reg       <= oper_next;
            step_reg       <= step_next;
            wait_reg       <= wait_next;
            ramped_reg     <= ramped_next;
            goal_reg       <= goal_next;
            pending_reg    <= pending_next;
            sent_vel_reg   <= sent_vel_next;
            sent_cmd_reg   <= sent_cmd_next;
            sent_newsp_reg <= sent_newsp_next;
        end
        in_valid_reg  <= in_valid_next;
        in_stop_reg   <= in_stop_next;
        in_status_reg <= in_status_next;
        in_shown_reg  <= in_shown_next;
        in_pos_reg    <= in_pos_next;
        in_fast_reg   <= in_fast_next;
        in_permit_reg <= in_permit_next;
        in_motion_reg <= in_motion_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        dsr_reg       <= dsr_next;
        cnt_reg       <= cnt_next;
        neg_reg       <= neg_next;
        zero_reg      <= zero_next;
    end

    // the operational phase is only entered from, and left back to, known steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        oper_reg |-> (step_reg == STEP_ENABLE))
        else $error("operational phase outside enable step");

    // once an item is taken the block stays busy for at least the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while previous item in progress");

    // the ramp can overshoot the limit by less than one step only
    assert property (@(posedge aclk) disable iff (!aresetn)
        (sent_vel_reg <= 18'sd65539) && (sent_vel_reg >= -18'sd65539))
        else $error("velocity setpoint out of range");

    // wait counter never runs past the longest timed step
    assert property (@(posedge aclk) disable iff (!aresetn)
        wait_reg <= (MODE_WAIT_CYCLES + 7'd1))
        else $error("wait counter overrun");

endmodule
